>>> rtl/cra_pkg.sv
// Package for the contiguous region allocator.
// Holds the sequencer states, operation, status and configuration codes and control structs.
// No dependencies.
package cra_pkg;

  // Operation codes carried in tuser of the input request
  localparam logic [2:0] FN_APPEND = 3'd0;
  localparam logic [2:0] FN_DONATE = 3'd1;
  localparam logic [2:0] FN_ALLOC  = 3'd2;
  localparam logic [2:0] FN_FREE   = 3'd3;
  localparam logic [2:0] FN_QUERY  = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_NO_SPACE  = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIAS_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR    = 2'd1;

  // Largest page count a region may hold
  localparam logic [20:0] PAGES_MAX = 21'h1FFFFF;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_APPEND, S_DFIND, S_DPREV, S_DNEXT, S_DSHDN, S_DSHUP,
    S_AFREE, S_AREG, S_AFIT, S_APREV, S_ADEC, S_LOOKUP, S_FINISH
  } cra_state_t;

  // Region table write controls
  typedef struct packed {
    logic we;
    logic inc;
    logic dec;
  } region_cmd_t;

  // Slot store write controls
  typedef struct packed {
    logic we;
    logic clr;
  } slot_cmd_t;

endpackage

>>> rtl/contiguous_region_allocator.sv
// Top level of the contiguous region allocator: sequencer and shared compare datapath.
// Depends on cra_pkg, cra_region_tab and cra_slot_store.
//
//  channel | direction | handshake          | payload
//  in_     | request   | in_tvalid/tready   | tuser func, tdata operands
//  out_    | result    | out_tvalid/tready  | tuser status, tdata alias and size
//  cfg_    | write     | cfg_valid/ready    | cfg_index, cfg_data
//
// One request at a time; in_tready is high only when the sequencer is idle.
// Append is one table update; donate walks the used regions, checks both neighbours
// and shifts entries. Allocate scans the N = ALLOC_SLOTS slots for a free one, then
// checks each region tried and rescans the slots per hole; the slot scan sets the
// rate. Free and query scan the slots once. A result waits in the output register.
// Reset is synchronous; the region table is cleared directly, no clearing pass.
module contiguous_region_allocator import cra_pkg::*; #(
  parameter int unsigned REGION_SLOTS = 16,
  parameter int unsigned ALLOC_SLOTS  = 64,
  parameter int unsigned PAGE_BITS    = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // [31:0] address, [51:32] page_count, [52] mark_low_reserve, [84:53] byte_count,
  // [116:85] low_bound, [148:117] high_bound, [180:149] alignment, [183:181] zero
  input  logic [183:0]         in_tdata,
  input  logic [2:0]           in_tuser,   // [2:0] func
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [63:0]          out_tdata,  // [31:0] result_alias, [63:32] result_size
  output logic [1:0]           out_tuser,  // [1:0] status
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int unsigned UW   = $clog2(REGION_SLOTS + 1);
  localparam int unsigned AW   = (ALLOC_SLOTS > 1) ? $clog2(ALLOC_SLOTS) : 1;
  localparam int unsigned CW   = $clog2(ALLOC_SLOTS + 1);
  localparam int unsigned RE_W = (((PAGE_BITS + 21) > 32) ? (PAGE_BITS + 21) : 32) + 1;
  localparam logic [32:0] PAGE_B = 33'(1) << PAGE_BITS;

  cra_state_t state_r, state_nxt;

  // Request fields and derived values
  logic [2:0]  func_r, func_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [19:0] pg_r, pg_nxt;
  logic        lr_r, lr_nxt;
  logic [31:0] nb_r, nb_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic [32:0] size_r, size_nxt, mask_r, mask_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [31:0] ralias_r, ralias_nxt, rsize_r, rsize_nxt;

  // Configuration and output register
  logic [31:0] base_r, base_nxt, thr_r, thr_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [31:0] out_alias_r, out_alias_nxt, out_size_r, out_size_nxt;

  // Region walk
  logic [UW-1:0] rc_r, rc_nxt, ri_r, ri_nxt, rr_r, rr_nxt;
  logic          pass_r, pass_nxt;
  logic          prev_ok_r, prev_ok_nxt;
  logic [31:0]   prev_start_r, prev_start_nxt;
  logic [20:0]   prev_pages_r, prev_pages_nxt;

  // Hole fitting
  logic [31:0]   hs_r, hs_nxt;
  logic [RE_W-1:0] he_r, he_nxt;
  logic [32:0]   cl_r, cl_nxt, next_r, next_nxt, bend_r, bend_nxt;
  logic [31:0]   bstart_r, bstart_nxt;
  logic          found_r, found_nxt;
  logic [AW-1:0] fidx_r, fidx_nxt;
  logic [32:0]   prevb_r, prevb_nxt, t_r, t_nxt;

  // Slot scan
  logic [CW-1:0] scnt_r, scnt_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pidx_r, pidx_nxt;

  // Region table port
  logic [UW-1:0]   rg_idx, rgw_idx;
  logic [31:0]     rg_start, rgw_start;
  logic [20:0]     rg_pages, rgw_pages;
  logic            rg_lr, rgw_lr;
  logic [RE_W-1:0] rg_end;
  logic [UW-1:0]   used;
  region_cmd_t     rg_cmd;

  // Slot store port
  logic          sd_valid;
  logic [31:0]   sd_start, sd_alias, sd_size;
  logic [32:0]   sd_end;
  slot_cmd_t     sl_cmd;
  logic [AW-1:0] sl_wr_addr;
  logic [32:0]   sl_wr_end;

  cra_region_tab #(.REGION_SLOTS(REGION_SLOTS), .PAGE_BITS(PAGE_BITS)) u_rtab (
    .clk, .rst_n, .rd_idx(rg_idx), .rd_start(rg_start), .rd_pages(rg_pages),
    .rd_lr(rg_lr), .rd_end(rg_end), .used, .cmd(rg_cmd), .wr_idx(rgw_idx),
    .wr_start(rgw_start), .wr_pages(rgw_pages), .wr_lr(rgw_lr)
  );

  cra_slot_store #(.ALLOC_SLOTS(ALLOC_SLOTS)) u_slots (
    .clk, .rst_n, .rd_addr(scnt_r[AW-1:0]), .rd_valid(sd_valid), .rd_start(sd_start),
    .rd_end(sd_end), .rd_alias(sd_alias), .rd_size(sd_size), .cmd(sl_cmd),
    .wr_addr(sl_wr_addr), .wr_start(t_r[31:0]), .wr_end(sl_wr_end),
    .wr_alias(base_r | t_r[31:0]), .wr_size(nb_r)
  );

  // Handshakes and outputs
  logic in_fire;
  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {out_size_r, out_alias_r};

  // Request decode at accept
  logic [32:0] in_nb33, in_al33, al_eff;
  assign in_nb33 = {1'b0, in_tdata[84:53]};
  assign in_al33 = {1'b0, in_tdata[180:149]};
  assign al_eff  = (in_al33 < PAGE_B) ? PAGE_B : in_al33;

  // Shared decisions
  logic        full, app_hit, find_step, prev_ok_c, has_next, next_join, next_ok;
  logic [20:0] newp;
  logic [RE_W-1:0] pend_e;
  logic [32:0] cl_c, hi1, ch_c;
  logic        cand, scan_done, fit_upd, lk_hit, fr_hit, fit_ok;
  logic        out_free;

  assign full      = (used == UW'(REGION_SLOTS));
  assign app_hit   = (used != '0) && (rg_end == RE_W'(addr_r)) &&
                     ((22'(rg_pages) + 22'(pg_r)) <= 22'(PAGES_MAX));
  assign find_step = (rc_r < used) && (rg_start <= addr_r);
  assign prev_ok_c = (ri_r != '0) && !rg_lr && (rg_end == RE_W'(addr_r)) &&
                     ((22'(rg_pages) + 22'(pg_r)) <= 22'(PAGES_MAX));
  assign pend_e    = RE_W'(addr_r) + (RE_W'(pg_r) << PAGE_BITS);
  assign has_next  = (ri_r < used);
  assign newp      = prev_pages_r + 21'(pg_r);
  assign next_join = has_next && !rg_lr && (RE_W'(rg_start) == pend_e) &&
                     ((22'(newp) + 22'(rg_pages)) <= 22'(PAGES_MAX));
  assign next_ok   = has_next && !rg_lr && (RE_W'(rg_start) == pend_e) &&
                     ((22'(rg_pages) + 22'(pg_r)) <= 22'(PAGES_MAX));
  assign cl_c      = (lo_r > rg_start) ? 33'(lo_r) : 33'(rg_start);
  assign hi1       = 33'(hi_r) + 33'd1;
  assign ch_c      = (RE_W'(hi1) < rg_end) ? hi1 : rg_end[32:0];
  assign cand      = (rg_lr == pass_r) && (rg_pages != '0) && (cl_c < ch_c);
  assign scan_done = (scnt_r == CW'(ALLOC_SLOTS)) && !pend_r;
  assign fit_upd   = pend_r && sd_valid && (sd_start >= hs_r) &&
                     (RE_W'(sd_start) < he_r) && (sd_end <= next_r) &&
                     (!found_r || (sd_end > bend_r));
  assign lk_hit    = pend_r && sd_valid && (sd_alias == addr_r) && !found_r;
  assign fr_hit    = pend_r && !sd_valid && !found_r;
  assign fit_ok    = (size_r <= (next_r - prevb_r)) && (t_r >= prevb_r);
  assign out_free  = !out_valid_r || out_tready;
  assign sl_wr_end = t_r + size_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_fire) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        priority case (func_r)
          FN_APPEND: state_nxt = (pg_r == '0) ? S_FINISH : S_APPEND;
          FN_DONATE: state_nxt = (pg_r == '0) ? S_FINISH : S_DFIND;
          FN_ALLOC:  state_nxt = (size_r == '0) ? S_FINISH : S_AFREE;
          FN_FREE, FN_QUERY: state_nxt = S_LOOKUP;
          default:   state_nxt = S_FINISH;
        endcase
      end
      S_APPEND:   state_nxt = S_FINISH;
      S_DFIND:    if (!find_step) state_nxt = S_DPREV;
      S_DPREV:    state_nxt = S_DNEXT;
      S_DNEXT: begin
        if (prev_ok_r) state_nxt = next_join ? S_DSHDN : S_FINISH;
        else if (next_ok || full) state_nxt = S_FINISH;
        else state_nxt = S_DSHUP;
      end
      S_DSHDN:    if ((rc_r + UW'(1)) >= used) state_nxt = S_FINISH;
      S_DSHUP:    if (rc_r <= ri_r) state_nxt = S_FINISH;
      S_AFREE:    if (scan_done) state_nxt = found_r ? S_AREG : S_FINISH;
      S_AREG: begin
        if (rr_r == '0) begin
          if (pass_r || !(hi_r < thr_r)) state_nxt = S_FINISH;
        end else if (cand) begin
          state_nxt = S_AFIT;
        end
      end
      S_AFIT:     if (scan_done) state_nxt = S_APREV;
      S_APREV:    state_nxt = S_ADEC;
      S_ADEC: begin
        if (fit_ok) state_nxt = S_FINISH;
        else if (found_r && (33'(bstart_r) > cl_r)) state_nxt = S_AFIT;
        else state_nxt = S_AREG;
      end
      S_LOOKUP:   if (scan_done) state_nxt = S_FINISH;
      S_FINISH:   if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Datapath and table controls
  always_comb begin
    func_nxt = func_r; addr_nxt = addr_r; pg_nxt = pg_r; lr_nxt = lr_r;
    nb_nxt = nb_r; lo_nxt = lo_r; hi_nxt = hi_r;
    size_nxt = size_r; mask_nxt = mask_r;
    status_nxt = status_r; ralias_nxt = ralias_r; rsize_nxt = rsize_r;
    base_nxt = base_r; thr_nxt = thr_r;
    out_valid_nxt = out_valid_r; out_status_nxt = out_status_r;
    out_alias_nxt = out_alias_r; out_size_nxt = out_size_r;
    rc_nxt = rc_r; ri_nxt = ri_r; rr_nxt = rr_r; pass_nxt = pass_r;
    prev_ok_nxt = prev_ok_r; prev_start_nxt = prev_start_r; prev_pages_nxt = prev_pages_r;
    hs_nxt = hs_r; he_nxt = he_r; cl_nxt = cl_r; next_nxt = next_r;
    bend_nxt = bend_r; bstart_nxt = bstart_r; found_nxt = found_r; fidx_nxt = fidx_r;
    prevb_nxt = prevb_r; t_nxt = t_r;
    scnt_nxt = scnt_r; pend_nxt = pend_r; pidx_nxt = pidx_r;
    rg_idx = '0; rgw_idx = '0; rgw_start = '0; rgw_pages = '0; rgw_lr = 1'b0;
    rg_cmd = '0; sl_cmd = '0; sl_wr_addr = fidx_r;

    // Take configuration writes
    if (cfg_valid) begin
      if (cfg_index == CFG_ALIAS_BASE) base_nxt = cfg_data;
      if (cfg_index == CFG_LOW_THR) thr_nxt = cfg_data;
    end

    // Drop the result once taken
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    // Advance the slot scan
    if (state_r == S_AFREE || state_r == S_AFIT || state_r == S_LOOKUP) begin
      if (scnt_r < CW'(ALLOC_SLOTS)) begin
        scnt_nxt = scnt_r + CW'(1);
        pend_nxt = 1'b1;
        pidx_nxt = scnt_r[AW-1:0];
      end else begin
        pend_nxt = 1'b0;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          func_nxt = in_tuser;
          addr_nxt = in_tdata[31:0];
          pg_nxt   = in_tdata[51:32];
          lr_nxt   = in_tdata[52];
          nb_nxt   = in_tdata[84:53];
          lo_nxt   = in_tdata[116:85];
          hi_nxt   = in_tdata[148:117];
          size_nxt = (in_nb33 + PAGE_B - 33'd1) & ~(PAGE_B - 33'd1);
          mask_nxt = ~(al_eff - 33'd1);
          status_nxt = ST_OK;
          ralias_nxt = '0;
          rsize_nxt  = '0;
        end
      end
      S_DISPATCH: begin
        if (func_r == FN_ALLOC && size_r == '0) status_nxt = ST_NO_SPACE;
        rc_nxt = '0;
        scnt_nxt = '0;
        pend_nxt = 1'b0;
        found_nxt = 1'b0;
      end
      S_APPEND: begin
        rg_idx = used - UW'(1);
        if (app_hit) begin
          rg_cmd.we = 1'b1;
          rgw_idx = used - UW'(1);
          rgw_start = rg_start;
          rgw_pages = rg_pages + 21'(pg_r);
          rgw_lr = rg_lr;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          rg_cmd.we = 1'b1;
          rg_cmd.inc = 1'b1;
          rgw_idx = used;
          rgw_start = addr_r;
          rgw_pages = 21'(pg_r);
          rgw_lr = lr_r;
        end
      end
      S_DFIND: begin
        rg_idx = rc_r;
        if (find_step) rc_nxt = rc_r + UW'(1);
        else ri_nxt = rc_r;
      end
      S_DPREV: begin
        rg_idx = ri_r - UW'(1);
        prev_ok_nxt = prev_ok_c;
        prev_start_nxt = rg_start;
        prev_pages_nxt = rg_pages;
      end
      S_DNEXT: begin
        rg_idx = ri_r;
        if (prev_ok_r) begin
          rg_cmd.we = 1'b1;
          rgw_idx = ri_r - UW'(1);
          rgw_start = prev_start_r;
          rgw_pages = next_join ? (newp + rg_pages) : newp;
          rc_nxt = ri_r;
        end else if (next_ok) begin
          rg_cmd.we = 1'b1;
          rgw_idx = ri_r;
          rgw_start = addr_r;
          rgw_pages = rg_pages + 21'(pg_r);
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          rc_nxt = used;
        end
      end
      S_DSHDN: begin
        // Close the gap left by the merged neighbour
        rg_idx = rc_r + UW'(1);
        rg_cmd.we = 1'b1;
        rgw_idx = rc_r;
        if ((rc_r + UW'(1)) < used) begin
          rgw_start = rg_start;
          rgw_pages = rg_pages;
          rgw_lr = rg_lr;
          rc_nxt = rc_r + UW'(1);
        end else begin
          rg_cmd.dec = 1'b1;
        end
      end
      S_DSHUP: begin
        // Open a gap at the insert position
        rg_idx = rc_r - UW'(1);
        rg_cmd.we = 1'b1;
        if (rc_r > ri_r) begin
          rgw_idx = rc_r;
          rgw_start = rg_start;
          rgw_pages = rg_pages;
          rgw_lr = rg_lr;
          rc_nxt = rc_r - UW'(1);
        end else begin
          rg_cmd.inc = 1'b1;
          rgw_idx = ri_r;
          rgw_start = addr_r;
          rgw_pages = 21'(pg_r);
        end
      end
      S_AFREE: begin
        if (fr_hit) begin
          found_nxt = 1'b1;
          fidx_nxt = pidx_r;
        end
        if (scan_done) begin
          if (found_r) begin
            pass_nxt = 1'b0;
            rr_nxt = used;
          end else begin
            status_nxt = ST_NO_SPACE;
          end
        end
      end
      S_AREG: begin
        rg_idx = rr_r - UW'(1);
        if (rr_r == '0) begin
          if (!pass_r && (hi_r < thr_r)) begin
            pass_nxt = 1'b1;
            rr_nxt = used;
          end else begin
            status_nxt = ST_NO_SPACE;
          end
        end else begin
          rr_nxt = rr_r - UW'(1);
          if (cand) begin
            hs_nxt = rg_start;
            he_nxt = rg_end;
            cl_nxt = cl_c;
            next_nxt = ch_c;
            scnt_nxt = '0;
            pend_nxt = 1'b0;
            found_nxt = 1'b0;
          end
        end
      end
      S_AFIT: begin
        // Keep the live slot with the highest end below the hole top
        if (fit_upd) begin
          found_nxt = 1'b1;
          bend_nxt = sd_end;
          bstart_nxt = sd_start;
        end
      end
      S_APREV: begin
        prevb_nxt = (found_r && (bend_r > cl_r)) ? bend_r : cl_r;
        t_nxt = (next_r - size_r) & mask_r;
      end
      S_ADEC: begin
        if (fit_ok) begin
          sl_cmd.we = 1'b1;
          ralias_nxt = base_r | t_r[31:0];
        end else if (found_r && (33'(bstart_r) > cl_r)) begin
          next_nxt = 33'(bstart_r);
          scnt_nxt = '0;
          pend_nxt = 1'b0;
          found_nxt = 1'b0;
        end
      end
      S_LOOKUP: begin
        if (lk_hit) begin
          found_nxt = 1'b1;
          fidx_nxt = pidx_r;
          rsize_nxt = sd_size;
        end
        if (scan_done) begin
          if (!found_r) status_nxt = ST_NOT_FOUND;
          else if (func_r == FN_FREE) sl_cmd.clr = 1'b1;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = status_r;
          out_alias_nxt = ralias_r;
          out_size_nxt = rsize_r;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      base_r <= 32'h8000_0000;
      thr_r <= 32'h0100_0000;
      scnt_r <= '0;
      pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      base_r <= base_nxt;
      thr_r <= thr_nxt;
      scnt_r <= scnt_nxt;
      pend_r <= pend_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    func_r <= func_nxt; addr_r <= addr_nxt; pg_r <= pg_nxt; lr_r <= lr_nxt;
    nb_r <= nb_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt;
    size_r <= size_nxt; mask_r <= mask_nxt;
    status_r <= status_nxt; ralias_r <= ralias_nxt; rsize_r <= rsize_nxt;
    out_status_r <= out_status_nxt; out_alias_r <= out_alias_nxt; out_size_r <= out_size_nxt;
    rc_r <= rc_nxt; ri_r <= ri_nxt; rr_r <= rr_nxt; pass_r <= pass_nxt;
    prev_ok_r <= prev_ok_nxt; prev_start_r <= prev_start_nxt; prev_pages_r <= prev_pages_nxt;
    hs_r <= hs_nxt; he_r <= he_nxt; cl_r <= cl_nxt; next_r <= next_nxt;
    bend_r <= bend_nxt; bstart_r <= bstart_nxt; found_r <= found_nxt; fidx_r <= fidx_nxt;
    prevb_r <= prevb_nxt; t_r <= t_nxt; pidx_r <= pidx_nxt;
  end

endmodule

>>> rtl/cra_region_tab.sv
// Region table: start, page count and low-reserve flag per region, plus fill count.
// One read port (combinational), one write port. Depends on cra_pkg.
module cra_region_tab import cra_pkg::*; #(
  parameter int unsigned REGION_SLOTS = 16,
  parameter int unsigned PAGE_BITS    = 12,
  parameter int unsigned RW   = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1,
  parameter int unsigned UW   = $clog2(REGION_SLOTS + 1),
  parameter int unsigned RE_W = (((PAGE_BITS + 21) > 32) ? (PAGE_BITS + 21) : 32) + 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [UW-1:0]   rd_idx,
  output logic [31:0]     rd_start,
  output logic [20:0]     rd_pages,
  output logic            rd_lr,
  output logic [RE_W-1:0] rd_end,
  output logic [UW-1:0]   used,
  input  region_cmd_t     cmd,
  input  logic [UW-1:0]   wr_idx,
  input  logic [31:0]     wr_start,
  input  logic [20:0]     wr_pages,
  input  logic            wr_lr
);

  logic [31:0]   start_r [REGION_SLOTS];
  logic [20:0]   pages_r [REGION_SLOTS];
  logic          lr_r    [REGION_SLOTS];
  logic [UW-1:0] used_r;

  // Read one entry and form its end address without wrap
  assign rd_start = start_r[rd_idx[RW-1:0]];
  assign rd_pages = pages_r[rd_idx[RW-1:0]];
  assign rd_lr    = lr_r[rd_idx[RW-1:0]];
  assign rd_end   = RE_W'(rd_start) + (RE_W'(rd_pages) << PAGE_BITS);
  assign used     = used_r;

  // Write one entry; reset clears the table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REGION_SLOTS; i++) begin
        start_r[i] <= '0;
        pages_r[i] <= '0;
        lr_r[i]    <= 1'b0;
      end
    end else if (cmd.we) begin
      start_r[wr_idx[RW-1:0]] <= wr_start;
      pages_r[wr_idx[RW-1:0]] <= wr_pages;
      lr_r[wr_idx[RW-1:0]]    <= wr_lr;
    end
  end

  // Track the fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (cmd.inc) begin
      used_r <= used_r + UW'(1);
    end else if (cmd.dec) begin
      used_r <= used_r - UW'(1);
    end
  end

endmodule

>>> rtl/cra_slot_store.sv
// Slot store: live allocations in memories with registered read, valid bits in flops.
// One read address and one write address per cycle. Depends on cra_pkg.
module cra_slot_store import cra_pkg::*; #(
  parameter int unsigned ALLOC_SLOTS = 64,
  parameter int unsigned AW = (ALLOC_SLOTS > 1) ? $clog2(ALLOC_SLOTS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_valid,
  output logic [31:0]   rd_start,
  output logic [32:0]   rd_end,
  output logic [31:0]   rd_alias,
  output logic [31:0]   rd_size,
  input  slot_cmd_t     cmd,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_start,
  input  logic [32:0]   wr_end,
  input  logic [31:0]   wr_alias,
  input  logic [31:0]   wr_size
);

  logic [31:0] start_mem [ALLOC_SLOTS];
  logic [32:0] end_mem   [ALLOC_SLOTS];
  logic [31:0] alias_mem [ALLOC_SLOTS];
  logic [31:0] size_mem  [ALLOC_SLOTS];
  logic [ALLOC_SLOTS-1:0] valid_r;

  // Write a new allocation
  always_ff @(posedge clk) begin
    if (cmd.we) begin
      start_mem[wr_addr] <= wr_start;
      end_mem[wr_addr]   <= wr_end;
      alias_mem[wr_addr] <= wr_alias;
      size_mem[wr_addr]  <= wr_size;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_start <= start_mem[rd_addr];
    rd_end   <= end_mem[rd_addr];
    rd_alias <= alias_mem[rd_addr];
    rd_size  <= size_mem[rd_addr];
    rd_valid <= valid_r[rd_addr];
  end

  // Set on allocation, drop on free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (cmd.we) valid_r[wr_addr] <= 1'b1;
      if (cmd.clr) valid_r[wr_addr] <= 1'b0;
    end
  end

endmodule

>>> rtl/cra_checker.sv
// Port-level checker for the contiguous region allocator, bound to the top level.
// Depends on cra_pkg and contiguous_region_allocator.
module cra_checker import cra_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // One request at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  // A failed request carries no alias
  a_fail_alias: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata[31:0] == 32'd0)
    else $error("alias on failed request");

  // A missed lookup carries no size
  a_miss_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_NOT_FOUND |-> out_tdata[63:32] == 32'd0)
    else $error("size on missed lookup");

endmodule

bind contiguous_region_allocator cra_checker u_cra_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);

>>> tb/tb.sv
// Self-checking bench for contiguous_region_allocator: region appends and donations,
// allocations, frees and queries are checked against a behavioural allocator model.
// Depends on cra_pkg and the contiguous_region_allocator RTL.
module tb;
  import cra_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NREG = 16;
  localparam int NSLOT = 64;
  localparam int PB = 12;
  localparam logic [63:0] PAGE = 64'd1 << PB;
  localparam logic [31:0] PMAX = 32'h1FFFFF;
  localparam longint CYCLE_LIMIT = 50000000;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] address;
    logic [19:0] pages;
    logic        lowres;
    logic [31:0] nbytes;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] align;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] alias_v;
    logic [31:0] size;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [183:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  contiguous_region_allocator dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Allocator shadow state
  logic [31:0] m_alias_base, m_low_thr;
  logic [31:0] rg_start[NREG];
  logic [31:0] rg_pages[NREG];
  logic        rg_low[NREG];
  int          rg_used;
  logic        sl_valid[NSLOT];
  logic [31:0] sl_start[NSLOT];
  logic [63:0] sl_end[NSLOT];
  logic [31:0] sl_size[NSLOT];
  logic [31:0] sl_alias[NSLOT];

  req_t pending_reqs[$];
  res_t expected_results[$];
  int errors = 0;
  int idle_pct = 0, stall_pct = 0;
  bit hold_off = 0;
  longint cycles = 0;

  function automatic logic [63:0] rg_end(int r);
    return {32'd0, rg_start[r]} + ({32'd0, rg_pages[r]} << PB);
  endfunction

  function automatic void model_reset();
    m_alias_base = 32'h8000_0000;
    m_low_thr = 32'h0100_0000;
    rg_used = 0;
    for (int i = 0; i < NREG; i++) begin
      rg_start[i] = '0; rg_pages[i] = '0; rg_low[i] = 1'b0;
    end
    for (int i = 0; i < NSLOT; i++) begin
      sl_valid[i] = 1'b0; sl_start[i] = '0; sl_end[i] = '0; sl_size[i] = '0; sl_alias[i] = '0;
    end
  endfunction

  function automatic logic [1:0] append_region(logic [31:0] pa, logic [31:0] pg, logic lr);
    int p;
    if (pg == 0) return ST_OK;
    if (rg_used > 0) begin
      p = rg_used - 1;
      if (rg_end(p) == {32'd0, pa} && rg_pages[p] + pg <= PMAX) begin
        rg_pages[p] += pg;
        return ST_OK;
      end
    end
    if (rg_used >= NREG) return ST_FULL;
    rg_start[rg_used] = pa; rg_pages[rg_used] = pg; rg_low[rg_used] = lr;
    rg_used++;
    return ST_OK;
  endfunction

  function automatic logic [1:0] donate_region(logic [31:0] pa, logic [31:0] pg);
    logic [63:0] pend;
    int i;
    pend = {32'd0, pa} + ({32'd0, pg} << PB);
    if (pg == 0) return ST_OK;
    for (i = 0; i < rg_used; i++)
      if (rg_start[i] > pa) break;
    if (i > 0 && !rg_low[i-1] && rg_end(i-1) == {32'd0, pa} && rg_pages[i-1] + pg <= PMAX) begin
      rg_pages[i-1] += pg;
      // close the gap to the next region when it abuts too
      if (i < rg_used && !rg_low[i] && {32'd0, rg_start[i]} == pend &&
          rg_pages[i-1] + rg_pages[i] <= PMAX) begin
        rg_pages[i-1] += rg_pages[i];
        for (int j = i; j + 1 < rg_used; j++) begin
          rg_start[j] = rg_start[j+1]; rg_pages[j] = rg_pages[j+1]; rg_low[j] = rg_low[j+1];
        end
        rg_used--;
        rg_start[rg_used] = '0; rg_pages[rg_used] = '0; rg_low[rg_used] = 1'b0;
      end
      return ST_OK;
    end
    if (i < rg_used && !rg_low[i] && {32'd0, rg_start[i]} == pend &&
        rg_pages[i] + pg <= PMAX) begin
      rg_start[i] = pa; rg_pages[i] += pg;
      return ST_OK;
    end
    if (rg_used >= NREG) return ST_FULL;
    for (int j = rg_used; j > i; j--) begin
      rg_start[j] = rg_start[j-1]; rg_pages[j] = rg_pages[j-1]; rg_low[j] = rg_low[j-1];
    end
    rg_start[i] = pa; rg_pages[i] = pg; rg_low[i] = 1'b0;
    rg_used++;
    return ST_OK;
  endfunction

  // Top-down first fit between live slots of one region
  function automatic bit fit_in_region(int r, logic [63:0] sz, logic [63:0] al,
                                       logic [63:0] lo, logic [63:0] hi,
                                       output logic [63:0] pa);
    logic [63:0] hs, he, cl, ch, nxt, prv, t;
    int pick;
    bit found;
    pa = '0;
    if (rg_pages[r] == 0) return 0;
    hs = {32'd0, rg_start[r]};
    he = rg_end(r);
    cl = lo > hs ? lo : hs;
    ch = (hi + 1 < he) ? hi + 1 : he;
    if (cl >= ch) return 0;
    nxt = ch;
    for (int it = 0; it <= NSLOT; it++) begin
      prv = cl; pick = 0; found = 0;
      for (int j = 0; j < NSLOT; j++) begin
        if (!sl_valid[j]) continue;
        if ({32'd0, sl_start[j]} < hs || {32'd0, sl_start[j]} >= he) continue;
        if (sl_end[j] > nxt) continue;
        if (!found || sl_end[j] > sl_end[pick]) begin
          pick = j; found = 1;
        end
      end
      if (found && sl_end[pick] > prv) prv = sl_end[pick];
      if (sz <= nxt - prv) begin
        t = (nxt - sz) & ~(al - 1);
        if (t >= prv) begin
          pa = t;
          return 1;
        end
      end
      if (!found) return 0;
      nxt = {32'd0, sl_start[pick]};
      if (nxt <= cl) return 0;
    end
    return 0;
  endfunction

  function automatic logic [1:0] allocate_block(logic [31:0] nb, logic [31:0] lo,
                                                logic [31:0] hi, logic [31:0] alg,
                                                output logic [31:0] al_out);
    logic [63:0] sz, al, pa;
    int slot;
    bit ok;
    al_out = '0;
    sz = ({32'd0, nb} + PAGE - 1) & ~(PAGE - 1);
    al = ({32'd0, alg} < PAGE) ? PAGE : {32'd0, alg};
    ok = 0; pa = '0;
    if (sz == 0) return ST_NO_SPACE;
    for (slot = 0; slot < NSLOT; slot++)
      if (!sl_valid[slot]) break;
    if (slot >= NSLOT) return ST_NO_SPACE;
    for (int pass = 0; pass < 2 && !ok; pass++) begin
      if (pass == 1 && !(hi < m_low_thr)) break;
      for (int r = rg_used; r > 0 && !ok; r--) begin
        if (rg_low[r-1] != (pass == 1)) continue;
        ok = fit_in_region(r - 1, sz, al, {32'd0, lo}, {32'd0, hi}, pa);
      end
    end
    if (!ok) return ST_NO_SPACE;
    sl_valid[slot] = 1'b1;
    sl_start[slot] = pa[31:0];
    sl_end[slot] = pa + sz;
    sl_size[slot] = nb;
    sl_alias[slot] = m_alias_base | pa[31:0];
    al_out = sl_alias[slot];
    return ST_OK;
  endfunction

  function automatic res_t predict_result(req_t q);
    res_t r;
    r = '0;
    case (q.func)
      FN_APPEND: r.status = append_region(q.address, {12'd0, q.pages}, q.lowres);
      FN_DONATE: r.status = donate_region(q.address, {12'd0, q.pages});
      FN_ALLOC:  r.status = allocate_block(q.nbytes, q.lo, q.hi, q.align, r.alias_v);
      FN_FREE, FN_QUERY: begin
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < NSLOT; i++) begin
          if (sl_valid[i] && sl_alias[i] == q.address) begin
            r.size = sl_size[i];
            r.status = ST_OK;
            if (q.func == FN_FREE) begin
              sl_valid[i] = 1'b0; sl_start[i] = '0; sl_end[i] = '0;
              sl_size[i] = '0; sl_alias[i] = '0;
            end
            break;
          end
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  // Drive requests from the queue, predicting each one as it is accepted
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(predict_result(pending_reqs.pop_front()));
      end
      if ((!in_tvalid || in_tready) ) begin
        if (pending_reqs.size() > (in_tvalid && in_tready ? 0 : 0) &&
            $urandom_range(99) >= idle_pct) begin
          in_tvalid <= 1'b1;
          in_tuser <= pending_reqs[0].func;
          in_tdata <= {3'd0, pending_reqs[0].align, pending_reqs[0].hi, pending_reqs[0].lo,
                       pending_reqs[0].nbytes, pending_reqs[0].lowres, pending_reqs[0].pages,
                       pending_reqs[0].address};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Check results and randomise the receiver
  always @(posedge clk) begin
    res_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", {30'd0, out_tuser}, 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_tuser != want.status) report_mismatch("status", {30'd0, out_tuser},
                                                        {30'd0, want.status});
          if (out_tdata[31:0] != want.alias_v) report_mismatch("alias", out_tdata[31:0],
                                                               want.alias_v);
          if (out_tdata[63:32] != want.size) report_mismatch("size", out_tdata[63:32],
                                                             want.size);
        end
      end
      out_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end
  end

  // Abort on a hang
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic drain();
    while (pending_reqs.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_ALIAS_BASE) m_alias_base = val;
    else m_low_thr = val;
  endtask

  function automatic req_t mk(logic [2:0] f, logic [31:0] a, logic [19:0] pg, logic lr,
                              logic [31:0] nb, logic [31:0] lo, logic [31:0] hi,
                              logic [31:0] al);
    req_t q;
    q.func = f; q.address = a; q.pages = pg; q.lowres = lr;
    q.nbytes = nb; q.lo = lo; q.hi = hi; q.align = al;
    return q;
  endfunction

  function automatic logic [31:0] rnd_alias();
    int k;
    k = $urandom_range(NSLOT - 1);
    if (sl_valid[k] && $urandom_range(3) != 0) return sl_alias[k];
    return $urandom_range(1) ? $urandom : m_alias_base | ($urandom & 32'hFFFF_F000);
  endfunction

  // One random request, mostly well-formed around the current regions
  function automatic req_t rnd_req();
    req_t q;
    int sel, r;
    q.func = FN_QUERY;
    q.address = $urandom;
    q.lowres = 1'($urandom_range(1));
    q.nbytes = $urandom;
    q.lo = $urandom;
    q.hi = $urandom;
    q.align = $urandom;
    q.pages = 20'($urandom_range(1, 64));
    sel = $urandom_range(99);
    r = rg_used > 0 ? $urandom_range(rg_used - 1) : 0;
    if (sel < 8) begin
      q.func = FN_APPEND;
      if (rg_used > 0 && $urandom_range(1)) q.address = 32'(rg_end(rg_used - 1));
      else q.address = $urandom & 32'hFFFF_F000;
      if ($urandom_range(9) == 0) q.pages = 20'($urandom);
      if ($urandom_range(15) == 0) q.pages = 20'd0;
    end else if (sel < 16) begin
      q.func = FN_DONATE;
      case ($urandom_range(3))
        0: q.address = 32'(rg_end(r));
        1: q.address = rg_start[r] - ({12'd0, q.pages} << PB);
        default: q.address = $urandom & 32'hFFFF_F000;
      endcase
      if ($urandom_range(9) == 0) q.pages = 20'($urandom);
      if ($urandom_range(15) == 0) q.pages = 20'd0;
    end else if (sel < 60) begin
      q.func = FN_ALLOC;
      q.nbytes = $urandom_range(3) == 0 ? $urandom : $urandom_range(1, 40000);
      if ($urandom_range(31) == 0) q.nbytes = 0;
      q.lo = $urandom_range(2) != 0 ? 32'd0 : $urandom;
      q.hi = $urandom_range(2) != 0 ? 32'hFFFF_FFFF :
             ($urandom_range(1) ? 32'(rg_end(r) - 64'd1) : $urandom);
      q.align = $urandom_range(3) != 0 ? (32'd1 << $urandom_range(20)) : $urandom;
    end else if (sel < 80) begin
      q.func = FN_FREE; q.address = rnd_alias();
    end else if (sel < 95) begin
      q.func = FN_QUERY; q.address = rnd_alias();
    end else begin
      q.func = 3'($urandom_range(5, 7));
    end
    return q;
  endfunction

  // Feed random requests one at a time so the generator sees current state
  task automatic run_random(int n);
    for (int k = 0; k < n; k++) begin
      pending_reqs.push_back(rnd_req());
      while (pending_reqs.size() != 0 || expected_results.size() > 1) @(posedge clk);
    end
  endtask

  initial begin
    model_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: regions, merges, table full, extremes, special codes
    pending_reqs.push_back(mk(FN_APPEND, 32'h0000_0000, 20'd0, 1'b0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(FN_APPEND, 32'h0000_0000, 20'd256, 1'b1, 0, 0, 0, 0));
    pending_reqs.push_back(mk(FN_APPEND, 32'h0010_0000, 20'd256, 1'b0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(FN_APPEND, 32'h4000_0000, 20'hFFFFF, 1'b0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(FN_APPEND, 32'h4FFF_F000, 20'hFFFFF, 1'b0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(FN_APPEND, 32'h5FFF_E000, 20'hFFFFF, 1'b0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(FN_DONATE, 32'hFFF0_0000, 20'h100, 1'b1, 0, 0, 0, 0));
    pending_reqs.push_back(mk(FN_DONATE, 32'h0020_0000, 20'h40, 1'b0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(FN_DONATE, 32'h0024_0000, 20'h40, 1'b0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(FN_DONATE, 32'h001C_0000, 20'h40, 1'b0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(FN_ALLOC, 0, 20'd0, 1'b0, 32'd0, 0, 32'hFFFF_FFFF, 0));
    pending_reqs.push_back(mk(FN_ALLOC, 0, 20'd0, 1'b0, 32'd1, 0, 32'hFFFF_FFFF, 0));
    pending_reqs.push_back(mk(FN_ALLOC, 0, 20'd0, 1'b0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF));
    pending_reqs.push_back(mk(FN_ALLOC, 0, 20'd0, 1'b0, 32'h3000, 0, 32'h000F_FFFF,
                              32'h3000));
    pending_reqs.push_back(mk(FN_ALLOC, 0, 20'd0, 1'b0, 32'h1000, 32'hFFFF_FFFF, 32'd0,
                              32'd1));
    pending_reqs.push_back(mk(FN_QUERY, 32'h8000_0000, 20'd0, 1'b0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(FN_FREE, 32'h8000_0000, 20'd0, 1'b0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(FN_FREE, 32'hFFFF_FFFF, 20'd0, 1'b0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(3'd7, 32'hFFFF_FFFF, 20'hFFFFF, 1'b1, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_reqs.push_back(mk(3'd5, 0, 20'd0, 1'b0, 0, 0, 0, 0));
    for (int i = 0; i < 12; i++)
      pending_reqs.push_back(mk(FN_APPEND, 32'h7000_0000 + i * 32'h0100_0000, 20'd16,
                                i[0], 0, 0, 0, 0));
    drain();

    // Random phases across several register settings and idle mixes
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CFG_ALIAS_BASE, 32'd0); write_reg(CFG_LOW_THR, 32'hFFFF_FFFF); end
        1: begin write_reg(CFG_ALIAS_BASE, 32'hFFFF_FFFF); write_reg(CFG_LOW_THR, 32'd0); end
        default: begin
          write_reg(CFG_ALIAS_BASE, $urandom & 32'hF000_0000);
          write_reg(CFG_LOW_THR, $urandom);
        end
      endcase
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 53; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 53; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      // In phase 3, free every live block first
      if (ph == 3) begin
        for (int k = 0; k < NSLOT; k++)
          if (sl_valid[k])
            pending_reqs.push_back(mk(FN_FREE, sl_alias[k], 20'd0, 1'b0, 0, 0, 0, 0));
        drain();
      end
      run_random(240);
      drain();
    end

    // Receiver holds off in its own process while requests keep coming
    fork
      begin
        hold_off = 1;
        repeat (2000) @(posedge clk);
        hold_off = 0;
      end
      begin
        for (int k = 0; k < 6; k++) pending_reqs.push_back(rnd_req());
      end
    join
    drain();

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
